// ===== sv/assert_macros.svh =====
// Assertion macros used by the matrix multiplier controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property check with asynchronous active-low reset disable.
`define SQMM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Condition that must never be seen at a clock edge.
`define SQMM_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define SQMM_ASSERT(lbl, clk, rstn, prop)
`define SQMM_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== sv/sqmm_pkg.sv =====
// Shared constants, types and controller/datapath interface for the matrix multiplier.
package sqmm_pkg;

  localparam int unsigned ELEMENT_BITS  = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned MAX_SIZE_DEF  = 4;
  localparam int unsigned SIZE_BITS     = 3;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 3'd4;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic issue;     // read both stores this cycle (pipeline advancing)
    logic first;     // first term of a dot product
    logic last;      // last term of a dot product
    logic fin;       // last term of the last product element
    logic wr_en;     // store the accepted element
    logic wr_right;  // element belongs to the right matrix
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic advance;   // pipeline may move this cycle
  } stat_t;

endpackage

// ===== sv/sqmm_ctrl.sv =====
// Controller: size register, load sequencing and dot-product address generation.
module sqmm_ctrl #(
  parameter int unsigned MAX_SIZE = sqmm_pkg::MAX_SIZE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sqmm_pkg::SIZE_BITS-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  output sqmm_pkg::cmd_t                      cmd_o,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] wr_addr_o,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] l_addr_o,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] r_addr_o,
  input  sqmm_pkg::stat_t                     stat_i
);
  import sqmm_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(MAX_SIZE*MAX_SIZE);
  localparam int unsigned IW = $clog2(MAX_SIZE);
  localparam int unsigned NW = $clog2(MAX_SIZE+1);

  ctl_state_e           state_q, state_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic                 right_q, right_d;
  logic [IW-1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AW-1:0]        row_q, row_d, col_q, col_d;

  logic [31:0]   size_w;
  logic [NW-1:0] n;
  logic [2*NW-1:0] nn;
  logic [AW-1:0] nn_m1;
  logic [AW-1:0] n_a;
  logic [IW-1:0] n_m1;
  logic          accept, step, k_last, j_last, i_last;

  // effective size: clamp into 2..MAX_SIZE
  always_comb begin
    size_w = 32'(size_q);
    if (size_w < 32'd2) begin
      n = NW'(2);
    end else if (size_w > 32'(MAX_SIZE)) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(size_w);
    end
    nn    = (2*NW)'(n) * (2*NW)'(n);
    nn_m1 = AW'(nn - (2*NW)'(1));
    n_a   = AW'(n);
    n_m1  = IW'(n - NW'(1));
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_ready_o && in_valid_i;
  assign step       = (state_q == ST_RUN) && stat_i.advance;
  assign k_last     = (k_q == n_m1);
  assign j_last     = (j_q == n_m1);
  assign i_last     = (i_q == n_m1);

  assign wr_addr_o = ptr_q;
  assign l_addr_o  = row_q + AW'(k_q);
  assign r_addr_o  = col_q;

  always_comb begin
    cmd_o.issue    = step;
    cmd_o.first    = (k_q == '0);
    cmd_o.last     = k_last;
    cmd_o.fin      = k_last && j_last && i_last;
    cmd_o.wr_en    = accept;
    cmd_o.wr_right = right_q;
  end

  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    ptr_d   = ptr_q;
    right_d = right_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    row_d   = row_q;
    col_d   = col_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (ptr_q == nn_m1) begin
            ptr_d = '0;
            if (right_q) begin
              right_d = 1'b0;
              state_d = ST_RUN;
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              row_d   = '0;
              col_d   = '0;
            end else begin
              right_d = 1'b1;
            end
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end
      ST_RUN: begin
        if (step) begin
          if (!k_last) begin
            k_d   = k_q + IW'(1);
            col_d = col_q + n_a;
          end else begin
            k_d = '0;
            if (!j_last) begin
              j_d   = j_q + IW'(1);
              col_d = AW'(j_q) + AW'(1);
            end else begin
              j_d   = '0;
              col_d = '0;
              if (!i_last) begin
                i_d   = i_q + IW'(1);
                row_d = row_q + n_a;
              end else begin
                state_d = ST_LOAD;
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    // a size write drops any partial load
    if (cfg_we_i) begin
      size_d  = cfg_wdata_i;
      ptr_d   = '0;
      right_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      size_q  <= SIZE_RESET;
      ptr_q   <= '0;
      right_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      ptr_q   <= ptr_d;
      right_q <= right_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  `SQMM_ASSERT(a_fin_is_last_term, clk_i, rst_ni, cmd_o.fin && cmd_o.issue |-> cmd_o.last)
  `SQMM_ASSERT(a_fin_reopens_load, clk_i, rst_ni, (cmd_o.issue && cmd_o.fin) |=> in_ready_o)
  `SQMM_ASSERT(a_stall_holds_addr, clk_i, rst_ni, (state_q == ST_RUN && !stat_i.advance) |=> ($stable(l_addr_o) && $stable(r_addr_o)))
  `SQMM_ASSERT(a_run_starts_at_zero, clk_i, rst_ni, (accept && right_q && ptr_q == nn_m1 && !cfg_we_i) |=> (state_q == ST_RUN && l_addr_o == '0 && r_addr_o == '0))

endmodule

// ===== sv/sqmm_dp.sv =====
// Datapath: element stores, multiply-accumulate pipeline, scaling and output register.
module sqmm_dp #(
  parameter int unsigned MAX_SIZE = sqmm_pkg::MAX_SIZE_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  sqmm_pkg::cmd_t                             cmd_i,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]       wr_addr_i,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]       l_addr_i,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]       r_addr_i,
  input  logic signed [sqmm_pkg::ELEMENT_BITS-1:0]   element_value_i,
  output sqmm_pkg::stat_t                            stat_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [sqmm_pkg::ELEMENT_BITS-1:0]   product_value_o,
  output logic                                       is_last_o
);
  import sqmm_pkg::*;

  localparam int unsigned DEPTH = MAX_SIZE*MAX_SIZE;
  localparam int unsigned EB    = ELEMENT_BITS;
  localparam int unsigned ACW   = 2*EB + $clog2(MAX_SIZE);
  localparam logic signed [ACW-1:0] SAT_HI = {{(ACW-EB+1){1'b0}}, {(EB-1){1'b1}}};
  localparam logic signed [ACW-1:0] SAT_LO = {{(ACW-EB+1){1'b1}}, {(EB-1){1'b0}}};

  logic [EB-1:0] left_mem  [DEPTH];
  logic [EB-1:0] right_mem [DEPTH];

  logic                   adv;
  logic signed [EB-1:0]   l_rd_q, r_rd_q;
  logic                   v1_q, first1_q, last1_q, fin1_q;
  logic signed [2*EB-1:0] prod_q;
  logic                   v2_q, first2_q, last2_q, fin2_q;
  logic signed [ACW-1:0]  acc_q, prod_ext, shifted;
  logic                   done3_q, fin3_q;
  logic                   out_valid_q, is_last_q;
  logic signed [EB-1:0]   product_q, product_d;

  // whole pipeline moves only when the output register can take a result
  assign adv            = !out_valid_q || out_ready_i;
  assign stat_o.advance = adv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_right) begin
      left_mem[wr_addr_i] <= element_value_i;
    end
    if (cmd_i.wr_en && cmd_i.wr_right) begin
      right_mem[wr_addr_i] <= element_value_i;
    end
  end

  // registered store reads and multiplier stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_rd_q   <= left_mem[l_addr_i];
      r_rd_q   <= right_mem[r_addr_i];
      first1_q <= cmd_i.first;
      last1_q  <= cmd_i.last;
      fin1_q   <= cmd_i.fin;
      prod_q   <= (2*EB)'(l_rd_q) * (2*EB)'(r_rd_q);
      first2_q <= first1_q;
      last2_q  <= last1_q;
      fin2_q   <= fin1_q;
      fin3_q   <= fin2_q;
    end
  end

  assign prod_ext = ACW'(prod_q);
  assign shifted  = acc_q >>> FRACTION_BITS;

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      acc_q <= first2_q ? prod_ext : acc_q + prod_ext;
    end
  end

  always_comb begin
    if (shifted > SAT_HI) begin
      product_d = SAT_HI[EB-1:0];
    end else if (shifted < SAT_LO) begin
      product_d = SAT_LO[EB-1:0];
    end else begin
      product_d = shifted[EB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && done3_q) begin
      product_q <= product_d;
      is_last_q <= fin3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      done3_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      done3_q     <= v2_q && last2_q;
      out_valid_q <= done3_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = product_q;
  assign is_last_o       = is_last_q;

endmodule

// ===== sv/small_matrix_multiply_core.sv =====
// Top level of the square fixed-point matrix multiplier (sizes 2 up to MAX_SIZE).
//
// Usage: write matrix_size (3 bits) through cfg_we_i/cfg_wdata_i while idle;
// any write restarts the current load. Sizes below 2 act as 2, above MAX_SIZE
// as MAX_SIZE. Each request on the input channel (in_valid_i/in_ready_o)
// carries one signed Q16.16 element: n*n left elements row-major, then n*n
// right elements row-major. The element completing the right matrix starts
// the product; n*n results then leave on the output channel
// (out_valid_o/out_ready_i), row-major, is_last_o high on the final one.
// Each result is the exact dot product shifted right by 16 (toward minus
// infinity) and saturated to 32 bits.
// Loading accepts an element whenever in_valid_i is high. A single
// multiply-accumulate unit does the work, one term per cycle unless the
// receiver stalls the output register, so a product has n*n*n terms.
// Input is refused from the last element until the final term is issued.
// A stalled receiver freezes the whole MAC pipeline behind the output
// register; nothing is lost. Reset sets size 4, empties the pipeline and
// starts a fresh load; the stores keep stale data that is never read.
module small_matrix_multiply_core #(
  parameter int unsigned MAX_SIZE = sqmm_pkg::MAX_SIZE_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [sqmm_pkg::SIZE_BITS-1:0]           cfg_wdata_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [sqmm_pkg::ELEMENT_BITS-1:0] element_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [sqmm_pkg::ELEMENT_BITS-1:0] product_value_o,
  output logic                                     is_last_o
);
  import sqmm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SIZE*MAX_SIZE);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] wr_addr, l_addr, r_addr;

  // sequencer: size register, load pointer, i/j/k loop counters
  sqmm_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .l_addr_o    (l_addr),
    .r_addr_o    (r_addr),
    .stat_i      (stat)
  );

  // stores, MAC pipeline, scale/saturate and the output register
  sqmm_dp #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .wr_addr_i       (wr_addr),
    .l_addr_i        (l_addr),
    .r_addr_i        (r_addr),
    .element_value_i (element_value_i),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .product_value_o (product_value_o),
    .is_last_o       (is_last_o)
  );

endmodule
